// ----- rtl/coap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package coap_pkg;

    // Classification of each result
    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_HEADER_DONE = 3'd1,
        KIND_TOKEN       = 3'd2,
        KIND_OPT_HEADER  = 3'd3,
        KIND_OPT_VALUE   = 3'd4,
        KIND_PAY_MARKER  = 3'd5,
        KIND_PAYLOAD     = 3'd6
    } item_kind_t;

    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [15:0] OPT_NUM_MAX    = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/coap_message_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each byte passes the input register, then the result register, which it enters
// only when that register is free or draining.
// Throughput: one byte per cycle while results are taken; a byte may be taken while a
// result waits, as the input register and the result register decouple the two channels.
// The rate is set by the byte-wise parse state machine.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the parser
// to the first header byte with all held header and option fields cleared.
module coap_message_parser
    import coap_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_message,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       item_kind,
    output logic [1:0]       version,
    output logic [1:0]       msg_type,
    output logic [3:0]       token_length,
    output logic [7:0]       code,
    output logic [15:0]      message_id,
    output logic [15:0]      option_number,
    output logic [3:0]       option_length,
    output logic [7:0]       byte_out,
    output logic             truncated,
    output logic             last
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_OPTHDR,
        PH_OPTVAL,
        PH_PAYLOAD
    } phase_t;

    // input register
    logic        in_valid_reg;
    logic [7:0]  din_reg;
    logic        eom_reg;

    // parse state
    phase_t      phase_reg,     phase_next;
    logic [1:0]  hdr_idx_reg,   hdr_idx_next;
    logic [3:0]  tok_rem_reg,   tok_rem_next;
    logic [3:0]  val_rem_reg,   val_rem_next;
    logic [15:0] opt_num_reg,   opt_num_next;
    logic [7:0]  first_reg,     first_next;
    logic [7:0]  code_reg,      code_next;
    logic [15:0] msg_id_reg,    msg_id_next;
    logic [3:0]  opt_len_reg,   opt_len_next;

    // result register
    logic        out_valid_reg;
    item_kind_t  kind_reg,      kind_next;
    logic [7:0]  pass_reg,      pass_next;
    logic        trunc_reg,     trunc_next;
    logic        last_reg;

    logic        advance;
    logic [16:0] opt_sum;

    // Move the held byte into the result register when that register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign opt_sum  = {1'b0, opt_num_reg} + {13'd0, din_reg[7:4]};

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        tok_rem_next = tok_rem_reg;
        val_rem_next = val_rem_reg;
        opt_num_next = opt_num_reg;
        first_next   = first_reg;
        code_next    = code_reg;
        msg_id_next  = msg_id_reg;
        opt_len_next = opt_len_reg;
        kind_next    = KIND_HEADER;
        pass_next    = 8'd0;
        trunc_next   = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                unique case (hdr_idx_reg)
                    2'd0:
                    begin
                        // first header byte opens a new message
                        first_next   = din_reg;
                        code_next    = 8'd0;
                        msg_id_next  = 16'd0;
                        opt_num_next = 16'd0;
                        opt_len_next = 4'd0;
                    end
                    2'd1:    code_next   = din_reg;
                    2'd2:    msg_id_next = {din_reg, 8'd0};
                    default: msg_id_next = {msg_id_reg[15:8], din_reg};
                endcase
                if (hdr_idx_reg == 2'd3)
                begin
                    kind_next    = KIND_HEADER_DONE;
                    hdr_idx_next = 2'd0;
                    tok_rem_next = first_reg[3:0];
                    phase_next   = (first_reg[3:0] != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                    trunc_next   = eom_reg && (first_reg[3:0] != 4'd0);
                end
                else
                begin
                    kind_next    = KIND_HEADER;
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    trunc_next   = eom_reg;
                end
            end
            PH_TOKEN:
            begin
                kind_next    = KIND_TOKEN;
                pass_next    = din_reg;
                tok_rem_next = tok_rem_reg - 4'd1;
                if (tok_rem_reg == 4'd1)
                    phase_next = PH_OPTHDR;
                else
                    trunc_next = eom_reg;
            end
            PH_OPTHDR:
            begin
                if (din_reg == PAYLOAD_MARKER)
                begin
                    kind_next  = KIND_PAY_MARKER;
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    kind_next    = KIND_OPT_HEADER;
                    // delta nibble taken at face value, sum saturates
                    opt_num_next = opt_sum[16] ? OPT_NUM_MAX : opt_sum[15:0];
                    opt_len_next = din_reg[3:0];
                    val_rem_next = din_reg[3:0];
                    if (din_reg[3:0] != 4'd0)
                    begin
                        phase_next = PH_OPTVAL;
                        trunc_next = eom_reg;
                    end
                end
            end
            PH_OPTVAL:
            begin
                kind_next    = KIND_OPT_VALUE;
                pass_next    = din_reg;
                val_rem_next = val_rem_reg - 4'd1;
                if (val_rem_reg == 4'd1)
                    phase_next = PH_OPTHDR;
                else
                    trunc_next = eom_reg;
            end
            default:
            begin
                kind_next = KIND_PAYLOAD;
                pass_next = din_reg;
            end
        endcase

        // final byte: back to the header for the next message
        if (eom_reg)
        begin
            phase_next   = PH_HEADER;
            hdr_idx_next = 2'd0;
            tok_rem_next = 4'd0;
            val_rem_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= 2'd0;
            tok_rem_reg   <= 4'd0;
            val_rem_reg   <= 4'd0;
            opt_num_reg   <= 16'd0;
            first_reg     <= 8'd0;
            code_reg      <= 8'd0;
            msg_id_reg    <= 16'd0;
            opt_len_reg   <= 4'd0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                tok_rem_reg <= tok_rem_next;
                val_rem_reg <= val_rem_next;
                opt_num_reg <= opt_num_next;
                first_reg   <= first_next;
                code_reg    <= code_next;
                msg_id_reg  <= msg_id_next;
                opt_len_reg <= opt_len_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            din_reg <= data_byte;
            eom_reg <= end_of_message;
        end
        if (advance)
        begin
            kind_reg  <= kind_next;
            pass_reg  <= pass_next;
            trunc_reg <= trunc_next;
            last_reg  <= eom_reg;
        end
    end

    // Held fields are shown after this byte's update, so they come straight from state.
    assign out_valid     = out_valid_reg;
    assign item_kind     = kind_reg;
    assign version       = first_reg[7:6];
    assign msg_type      = first_reg[5:4];
    assign token_length  = first_reg[3:0];
    assign code          = code_reg;
    assign message_id    = msg_id_reg;
    assign option_number = opt_num_reg;
    assign option_length = opt_len_reg;
    assign byte_out      = pass_reg;
    assign truncated     = trunc_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ----- rtl/coap_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module coap_checker
    import coap_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  item_kind,
    input wire logic [7:0]  byte_out,
    input wire logic        truncated,
    input wire logic        last
);

    // a waiting result holds its classification
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(byte_out))
        else $error("result changed while stalled");

    // only token, option value and payload carry a byte
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_TOKEN && item_kind != KIND_OPT_VALUE
            && item_kind != KIND_PAYLOAD |-> byte_out == 8'd0)
        else $error("byte passed on a non-data item");

    // truncation only on a final byte, never on the payload marker or in the payload
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last && item_kind != KIND_PAY_MARKER
            && item_kind != KIND_PAYLOAD)
        else $error("bad truncation flag");

    // a message ending within the first three header bytes is truncated
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && item_kind == KIND_HEADER |-> truncated)
        else $error("short header not flagged");

endmodule

bind coap_message_parser coap_checker u_coap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item_kind (item_kind),
    .byte_out  (byte_out),
    .truncated (truncated),
    .last      (last)
);

`default_nettype wire
